[design/lbup_pkg.sv]
// shared types, constants and helper functions of the letterbox upscaler
package lbup_pkg;

   localparam int IMAGE_SIDE  = 64;
   localparam int MAX_SCALE   = 8;
   localparam int MAX_DISPLAY = 4096;

   localparam int POS_W   = 12;
   localparam int DIM_W   = 13;
   localparam int PIX_W   = 32;
   localparam int REQ_W   = 2 * POS_W + PIX_W;
   localparam int CSR_AW  = 1;
   localparam int SCALE_W = 5;
   localparam int REC_K   = 17;
   localparam int REC_W   = REC_K + 1;

   // background gradient runs over this many shades from top to bottom
   localparam int SHADE_SPAN = 32;
   localparam int SHADE_W    = $clog2(SHADE_SPAN);

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd1024;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd768;

   localparam logic [7:0] BG_ALPHA   = 8'hff;
   localparam logic [7:0] SHADE_BASE = 8'h10;
   localparam logic [7:0] BLUE_LIFT  = 8'h08;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [CSR_AW-1:0] {
      REG_DISPLAY_WIDTH  = 1'b0,
      REG_DISPLAY_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] left;
      logic [DIM_W-1:0] top;
      logic [DIM_W-1:0] shown_w;
      logic [DIM_W-1:0] shown_h;
      logic [REC_W-1:0] recip;
   } geom_type;

   typedef struct packed {
      logic load_b;
      logic load_c;
   } pipe_en_type;

   // ceil(2^REC_K / scale): floor(n * recip >> REC_K) equals n / scale for 12-bit n
   function automatic logic [REC_W-1:0] recip_lut(input logic [SCALE_W-1:0] s);
      logic [REC_W-1:0] r;
      case (s)
         5'd1:    r = 18'd131072;
         5'd2:    r = 18'd65536;
         5'd3:    r = 18'd43691;
         5'd4:    r = 18'd32768;
         5'd5:    r = 18'd26215;
         5'd6:    r = 18'd21846;
         5'd7:    r = 18'd18725;
         5'd8:    r = 18'd16384;
         5'd9:    r = 18'd14564;
         5'd10:   r = 18'd13108;
         5'd11:   r = 18'd11916;
         5'd12:   r = 18'd10923;
         5'd13:   r = 18'd10083;
         5'd14:   r = 18'd9363;
         5'd15:   r = 18'd8739;
         5'd16:   r = 18'd8192;
         default: r = 18'd131072;
      endcase
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] d;
      d = v;
      if (d == '0) d = DIM_W'(1);
      if (d > DIM_W'(MAX_DISPLAY)) d = DIM_W'(MAX_DISPLAY);
      return d;
   endfunction

   function automatic logic [PIX_W-1:0] bg_color(input logic [SHADE_W-1:0] q);
      logic [7:0] shade;
      shade = SHADE_BASE + 8'(q);
      return {BG_ALPHA, shade, shade, shade + BLUE_LIFT};
   endfunction

endpackage

[design/lbup_geometry.sv]
// display size registers and the derived scale, centering offsets and reciprocal
module lbup_geometry #(
   parameter int IMAGE_SIDE = lbup_pkg::IMAGE_SIDE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lbup_pkg::CSR_AW-1:0]      csr_addr,
   input  logic [lbup_pkg::DIM_W-1:0]       csr_wdata,
   output lbup_pkg::geom_type               geom
);

   lbup_pkg::geom_type geom_ff, geom_in;

   // largest s in 1..MAX_SCALE with s * IMAGE_SIDE <= d, or 1 when no s fits
   function automatic logic [lbup_pkg::SCALE_W-1:0] fit(input logic [lbup_pkg::DIM_W-1:0] d);
      logic [lbup_pkg::SCALE_W-1:0] s;
      s = lbup_pkg::SCALE_W'(1);
      for (int k = 2; k <= lbup_pkg::MAX_SCALE; k++) begin
         if (int'(d) >= k * IMAGE_SIDE) s = lbup_pkg::SCALE_W'(k);
      end
      return s;
   endfunction

   logic [lbup_pkg::DIM_W-1:0]   width_n, height_n, span, shown_w, shown_h;
   logic [lbup_pkg::SCALE_W-1:0] scale_w, scale_h, scale;

   // derived values follow the register write in the same edge
   always_comb begin
      width_n  = geom_ff.width;
      height_n = geom_ff.height;
      if (csr_we && csr_addr == lbup_pkg::REG_DISPLAY_WIDTH) begin
         width_n = lbup_pkg::clamp_dim(csr_wdata);
      end
      if (csr_we && csr_addr == lbup_pkg::REG_DISPLAY_HEIGHT) begin
         height_n = lbup_pkg::clamp_dim(csr_wdata);
      end
      if (reset) begin
         width_n  = lbup_pkg::RESET_WIDTH;
         height_n = lbup_pkg::RESET_HEIGHT;
      end
      scale_w = fit(width_n);
      scale_h = fit(height_n);
      scale   = (scale_h < scale_w) ? scale_h : scale_w;
      span    = lbup_pkg::DIM_W'(IMAGE_SIDE) * lbup_pkg::DIM_W'(scale);
      shown_w = (span > width_n) ? width_n : span;
      shown_h = (span > height_n) ? height_n : span;

      geom_in.width   = width_n;
      geom_in.height  = height_n;
      geom_in.shown_w = shown_w;
      geom_in.shown_h = shown_h;
      geom_in.left    = (width_n - shown_w) >> 1;
      geom_in.top     = (height_n - shown_h) >> 1;
      geom_in.recip   = lbup_pkg::recip_lut(scale);
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

[design/lbup_bg_div.sv]
// two-stage restoring divider for the background shade, row * SHADE_SPAN / height
module lbup_bg_div (
   input  logic                          clock,
   input  lbup_pkg::pipe_en_type         en,
   input  logic [lbup_pkg::POS_W-1:0]    row,
   input  logic [lbup_pkg::DIM_W-1:0]    height,
   output logic [lbup_pkg::SHADE_W-1:0]  shade_q
);

   localparam int FIRST_STEPS = 3;

   logic [lbup_pkg::DIM_W-1:0]   rem_ff, rem_in;
   logic [lbup_pkg::SHADE_W-1:0] part_ff, part_in;
   logic [lbup_pkg::SHADE_W-1:0] shade_ff, shade_in;

   // row < height on every query that uses the shade, so the remainder stays below height
   always_comb begin
      logic [lbup_pkg::DIM_W:0] r2;
      rem_in  = lbup_pkg::DIM_W'(row);
      part_in = '0;
      for (int k = 0; k < FIRST_STEPS; k++) begin
         r2 = {rem_in, 1'b0};
         if (r2 >= {1'b0, height}) begin
            part_in = {part_in[lbup_pkg::SHADE_W-2:0], 1'b1};
            rem_in  = lbup_pkg::DIM_W'(r2 - {1'b0, height});
         end else begin
            part_in = {part_in[lbup_pkg::SHADE_W-2:0], 1'b0};
            rem_in  = r2[lbup_pkg::DIM_W-1:0];
         end
      end
   end

   always_comb begin
      logic [lbup_pkg::DIM_W:0]   r2;
      logic [lbup_pkg::DIM_W-1:0] r;
      r        = rem_ff;
      shade_in = part_ff;
      for (int k = FIRST_STEPS; k < lbup_pkg::SHADE_W; k++) begin
         r2 = {r, 1'b0};
         if (r2 >= {1'b0, height}) begin
            shade_in = {shade_in[lbup_pkg::SHADE_W-2:0], 1'b1};
            r        = lbup_pkg::DIM_W'(r2 - {1'b0, height});
         end else begin
            shade_in = {shade_in[lbup_pkg::SHADE_W-2:0], 1'b0};
            r        = r2[lbup_pkg::DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.load_b) begin
         rem_ff  <= rem_in;
         part_ff <= part_in;
      end
      if (en.load_c) begin
         shade_ff <= shade_in;
      end
   end

   assign shade_q = shade_ff;

endmodule

[design/lbup_image_ram.sv]
// source image memory, one write and one registered read per cycle while en is high
module lbup_image_ram #(
   parameter int IMAGE_SIDE = lbup_pkg::IMAGE_SIDE,
   localparam int DEPTH     = IMAGE_SIDE * IMAGE_SIDE,
   localparam int AW        = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic                        we,
   input  logic [AW-1:0]               waddr,
   input  logic [lbup_pkg::PIX_W-1:0]  wdata,
   input  logic                        re,
   input  logic [AW-1:0]               raddr,
   output logic [lbup_pkg::PIX_W-1:0]  rdata
);

   logic [lbup_pkg::PIX_W-1:0] mem [DEPTH];
   logic [lbup_pkg::PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[waddr] <= wdata;
      end
      if (en && re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/letterbox_integer_upscaler.sv]
// top level of the letterbox upscaler: request pipeline, image memory and result register
//
//  channel | direction | handshake           | payload
//  req     | in        | req_tvalid/tready   | tdata {pixel_in, pos_y, pos_x}, tuser command
//  rsp     | out       | rsp_tvalid/tready   | tdata color, tuser in_image
//  csr     | in        | csr_we              | csr_addr register index, csr_wdata value
//
// one transaction per cycle in sustained flow while the result side is not stalled; a
// query result passes through stage a, the address multiply in stage b, the memory read
// in stage c and the result register.
// writes take the same path and leave no result.
// synchronous reset clears the stage valid bits and restores the display size registers.
// a stalled result stalls the stages behind it only as they fill; bubbles are squeezed out.
module letterbox_integer_upscaler #(
   parameter int IMAGE_SIDE = lbup_pkg::IMAGE_SIDE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lbup_pkg::REQ_W-1:0]    req_tdata,  // pos_x, pos_y, pixel_in
   input  logic                          req_tuser,  // command
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lbup_pkg::PIX_W-1:0]    rsp_tdata,  // color
   output logic                          rsp_tuser,  // in_image
   input  logic                          csr_we,
   input  logic [lbup_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [lbup_pkg::DIM_W-1:0]    csr_wdata
);

   localparam int CW     = $clog2(IMAGE_SIDE);
   localparam int AW     = $clog2(IMAGE_SIDE * IMAGE_SIDE);
   localparam int PROD_W = lbup_pkg::POS_W + lbup_pkg::REC_W;
   localparam int POS_W  = lbup_pkg::POS_W;
   localparam int DIM_W  = lbup_pkg::DIM_W;
   localparam int PIX_W  = lbup_pkg::PIX_W;

   lbup_pkg::geom_type    geom;
   lbup_pkg::pipe_en_type en;

   lbup_geometry #(.IMAGE_SIDE(IMAGE_SIDE)) u_geometry (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   // request unpacking and window test
   logic [POS_W-1:0]  req_x, req_y;
   logic [PIX_W-1:0]  req_pix;
   lbup_pkg::cmd_type req_cmd;
   logic [DIM_W-1:0]  x_off, y_off;
   logic              req_oob, req_inside;

   assign req_x   = req_tdata[POS_W-1:0];
   assign req_y   = req_tdata[2*POS_W-1:POS_W];
   assign req_pix = req_tdata[lbup_pkg::REQ_W-1:2*POS_W];
   assign req_cmd = lbup_pkg::cmd_type'(req_tuser);
   assign x_off   = {1'b0, req_x} - geom.left;
   assign y_off   = {1'b0, req_y} - geom.top;
   assign req_oob = ({1'b0, req_x} >= geom.width) || ({1'b0, req_y} >= geom.height);
   assign req_inside = ({1'b0, req_x} >= geom.left) && (x_off < geom.shown_w) &&
                       ({1'b0, req_y} >= geom.top) && (y_off < geom.shown_h);

   // stage a
   logic              a_valid_ff, a_valid_in, load_a;
   lbup_pkg::cmd_type a_cmd_ff;
   logic [POS_W-1:0]  a_x_ff, a_y_ff, a_dx_ff, a_dy_ff;
   logic [PIX_W-1:0]  a_pix_ff;
   logic              a_oob_ff, a_inside_ff;

   // stage b
   logic              b_valid_ff, b_valid_in;
   lbup_pkg::cmd_type b_cmd_ff;
   logic              b_wr_ok_ff, b_wr_ok_in;
   logic [AW-1:0]     b_waddr_ff, b_waddr_in;
   logic [PIX_W-1:0]  b_pix_ff;
   logic              b_oob_ff, b_inside_ff;
   logic [PROD_W-1:0] b_px_ff, b_px_in, b_py_ff, b_py_in;
   logic [CW-1:0]     src_x, src_y;
   logic [AW-1:0]     raddr;

   // stage c
   logic              c_valid_ff, c_valid_in;
   lbup_pkg::cmd_type c_cmd_ff;
   logic              c_oob_ff, c_inside_ff;
   logic [PIX_W-1:0]  c_rdata;
   logic [lbup_pkg::SHADE_W-1:0] c_shade;

   // result register
   logic              o_valid_ff, o_valid_in, o_load;
   logic [PIX_W-1:0]  o_color_ff, o_color_in;
   logic              o_in_ff, o_in_in;
   logic              free_o, c_go;

   // flow control: each stage loads when it is empty or its content moves on
   assign free_o    = !o_valid_ff || rsp_tready;
   assign c_go      = c_valid_ff && (c_cmd_ff == lbup_pkg::CMD_WRITE || free_o);
   assign en.load_c = !c_valid_ff || c_go;
   assign en.load_b = !b_valid_ff || en.load_c;
   assign load_a    = !a_valid_ff || en.load_b;
   assign o_load    = c_go && c_cmd_ff == lbup_pkg::CMD_QUERY;
   assign req_tready = load_a;

   assign a_valid_in = load_a ? req_tvalid : a_valid_ff;
   assign b_valid_in = en.load_b ? a_valid_ff : b_valid_ff;
   assign c_valid_in = en.load_c ? b_valid_ff : c_valid_ff;
   assign o_valid_in = o_load ? 1'b1 : (rsp_tready ? 1'b0 : o_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_cmd_ff    <= req_cmd;
         a_x_ff      <= req_x;
         a_y_ff      <= req_y;
         a_pix_ff    <= req_pix;
         a_oob_ff    <= req_oob;
         a_inside_ff <= req_inside;
         a_dx_ff     <= x_off[POS_W-1:0];
         a_dy_ff     <= y_off[POS_W-1:0];
      end
   end

   // source coordinate = offset / scale through the reciprocal
   assign b_px_in    = PROD_W'(a_dx_ff) * PROD_W'(geom.recip);
   assign b_py_in    = PROD_W'(a_dy_ff) * PROD_W'(geom.recip);
   assign b_wr_ok_in = (a_x_ff < POS_W'(IMAGE_SIDE)) && (a_y_ff < POS_W'(IMAGE_SIDE));
   assign b_waddr_in = AW'(a_y_ff[CW-1:0]) * AW'(IMAGE_SIDE) + AW'(a_x_ff[CW-1:0]);

   always_ff @(posedge clock) begin
      if (en.load_b) begin
         b_cmd_ff    <= a_cmd_ff;
         b_wr_ok_ff  <= b_wr_ok_in;
         b_waddr_ff  <= b_waddr_in;
         b_pix_ff    <= a_pix_ff;
         b_oob_ff    <= a_oob_ff;
         b_inside_ff <= a_inside_ff;
         b_px_ff     <= b_px_in;
         b_py_ff     <= b_py_in;
      end
   end

   assign src_x = b_px_ff[lbup_pkg::REC_K +: CW];
   assign src_y = b_py_ff[lbup_pkg::REC_K +: CW];
   assign raddr = AW'(src_y) * AW'(IMAGE_SIDE) + AW'(src_x);

   // writes and reads meet the memory in the same stage, so program order is kept
   lbup_image_ram #(.IMAGE_SIDE(IMAGE_SIDE)) u_image_ram (
      .clock (clock),
      .en    (en.load_c),
      .we    (b_valid_ff && b_cmd_ff == lbup_pkg::CMD_WRITE && b_wr_ok_ff),
      .waddr (b_waddr_ff),
      .wdata (b_pix_ff),
      .re    (b_valid_ff && b_cmd_ff == lbup_pkg::CMD_QUERY && b_inside_ff),
      .raddr (raddr),
      .rdata (c_rdata)
   );

   lbup_bg_div u_bg_div (
      .clock   (clock),
      .en      (en),
      .row     (a_y_ff),
      .height  (geom.height),
      .shade_q (c_shade)
   );

   always_ff @(posedge clock) begin
      if (en.load_c) begin
         c_cmd_ff    <= b_cmd_ff;
         c_oob_ff    <= b_oob_ff;
         c_inside_ff <= b_inside_ff;
      end
   end

   always_comb begin
      if (c_oob_ff) begin
         o_color_in = '0;
         o_in_in    = 1'b0;
      end else if (c_inside_ff) begin
         o_color_in = c_rdata;
         o_in_in    = 1'b1;
      end else begin
         o_color_in = lbup_pkg::bg_color(c_shade);
         o_in_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (o_load) begin
         o_color_ff <= o_color_in;
         o_in_ff    <= o_in_in;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_color_ff;
   assign rsp_tuser  = o_in_ff;

endmodule

[design/lbup_checker.sv]
// port-level checks of the letterbox upscaler, bound to the top level
module lbup_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [lbup_pkg::PIX_W-1:0]  rsp_tdata,
   input logic                        rsp_tuser
);

   // after reset the pipe is empty: no result, request side open
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("pipe not empty after reset");

   // a result must pass stage a, stage b, stage c and the result register after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset, 3) |-> !rsp_tvalid)
      else $error("result appeared earlier than the pipeline depth allows");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // background pixels are opaque grey-blue shades, or zero outside the display
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tdata != '0 |->
         rsp_tdata[31:24] == lbup_pkg::BG_ALPHA &&
         rsp_tdata[23:16] == rsp_tdata[15:8] &&
         rsp_tdata[7:0] == rsp_tdata[15:8] + lbup_pkg::BLUE_LIFT)
      else $error("malformed background pixel");

endmodule

bind letterbox_integer_upscaler lbup_checker u_lbup_checker (.*);
